// File: hw/rtl/rgb_to_hsv_converter_top_defines.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top_defines
// Assertion macros used by the converter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define RHC_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define RHC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: hw/rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  // Number of quotient bits, and so of division cells in the chain.
  localparam int QuotW   = 15;
  localparam int HRemW   = 24;
  localparam int HDivW   = 10;
  localparam int SRemW   = 17;
  localparam int SDivW   = 9;
  localparam int ByteW   = 8;

  // Hue units in one sixth of a turn, and in a full turn.
  localparam logic [11:0] SectorUnits = 12'd3840;
  localparam logic [14:0] FullTurn    = 15'd23040;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [QuotW-1:0] hue;
    logic [ByteW-1:0] saturation;
    logic [ByteW-1:0] brightness;
  } hsv_t;

  // Work in flight between two cells of the divider chain.
  typedef struct packed {
    logic [HRemW-1:0] hrem;
    logic [HDivW-1:0] hdiv;
    logic [QuotW-1:0] hq;
    logic [SRemW-1:0] srem;
    logic [SDivW-1:0] sdiv;
    logic [ByteW-1:0] sq;
    logic [ByteW-1:0] val;
  } cell_t;

endpackage

`default_nettype wire

// File: hw/rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Finds the extreme channels and forms the hue and saturation dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           valid_in,
  input  rhc_pkg::pixel_t     pix,
  output logic                valid,
  output rhc_pkg::cell_t      data
);

  logic [7:0]  r, g, b, mx, mn, d;
  logic [22:0] t;
  logic [22:0] dsec;
  rhc_pkg::cell_t data_next;

  assign r = pix.red;
  assign g = pix.green;
  assign b = pix.blue;

  // Largest and smallest channel.
  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
  end

  // Hue numerator; red is tested first, then green.
  always_comb begin
    dsec = 23'(d) * 23'(rhc_pkg::SectorUnits);
    if (mx == r) begin
      if (g >= b) t = 23'(g - b) * 23'(rhc_pkg::SectorUnits);
      else        t = 23'(6) * dsec - 23'(b - g) * 23'(rhc_pkg::SectorUnits);
    end else if (mx == g) begin
      if (b >= r) t = 23'(2) * dsec + 23'(b - r) * 23'(rhc_pkg::SectorUnits);
      else        t = 23'(2) * dsec - 23'(r - b) * 23'(rhc_pkg::SectorUnits);
    end else begin
      if (r >= g) t = 23'(4) * dsec + 23'(r - g) * 23'(rhc_pkg::SectorUnits);
      else        t = 23'(4) * dsec - 23'(g - r) * 23'(rhc_pkg::SectorUnits);
    end
  end

  // Rounded dividends; gray and black divide zero by one.
  always_comb begin
    data_next = '0;
    data_next.val = mx;
    if (d == 8'd0) begin
      data_next.hrem = '0;
      data_next.hdiv = 10'd1;
    end else begin
      data_next.hrem = {t, 1'b0} + 24'(d);
      data_next.hdiv = {1'b0, d, 1'b0};
    end
    if (mx == 8'd0) begin
      data_next.srem = '0;
      data_next.sdiv = 9'd1;
    end else begin
      data_next.srem = 17'(d) * 17'd510 + 17'(mx);
      data_next.sdiv = {mx, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell
// One restoring division step for the hue quotient and, where SHIFT is below eight, the saturation quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           valid_in,
  input  rhc_pkg::cell_t      data_in,
  output logic                valid,
  output rhc_pkg::cell_t      data
);

  localparam logic [3:0] HI = 4'(SHIFT);
  localparam logic [2:0] SI = 3'(SHIFT);

  logic [24:0] hd;
  logic [23:0] sd;
  logic        hge, sge;
  rhc_pkg::cell_t data_next;

  // Compare each remainder with its shifted divisor and subtract on success.
  always_comb begin
    hd  = 25'(data_in.hdiv) << SHIFT;
    sd  = 24'(data_in.sdiv) << SHIFT;
    hge = {1'b0, data_in.hrem} >= hd;
    sge = 24'(data_in.srem) >= sd;
    data_next = data_in;
    if (hge) begin
      data_next.hrem   = data_in.hrem - hd[23:0];
      data_next.hq[HI] = 1'b1;
    end
    if (sge && (SHIFT < rhc_pkg::ByteW)) begin
      data_next.srem   = data_in.srem - sd[16:0];
      data_next.sq[SI] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// Streaming RGB to HSV converter, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one pixel transfer every cycle unless stalled, and returns
// one HSV result per pixel, in order. Each pixel passes through the front
// stage register and then through the register of each of the 15 division
// cells before its result is presented. The front stage finds the extreme
// channels and the rounded dividends, then each cell of the row produces one
// hue quotient bit, and the last eight cells also one saturation bit each.
// The whole row moves together, so pixel_stall rises only while a finished
// result is held by hsv_stall.
`default_nettype none
`include "rgb_to_hsv_converter_top_defines.svh"

module rgb_to_hsv_converter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pixel_valid,
  output logic             pixel_stall,
  input  rhc_pkg::pixel_t  pixel,
  output logic             hsv_valid,
  input  wire logic        hsv_stall,
  output rhc_pkg::hsv_t    hsv
);

  localparam int N = rhc_pkg::QuotW;

  logic           adv;
  logic           black_out;
  logic           v   [N+1];
  rhc_pkg::cell_t dat [N+1];

  // The row advances unless the last result is being held.
  assign adv         = !(hsv_valid && hsv_stall);
  assign pixel_stall = !adv;

  rhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .valid_in (pixel_valid),
    .pix      (pixel),
    .valid    (v[0]),
    .data     (dat[0])
  );

  // Division cells, most significant quotient bit first.
  for (genvar k = 0; k < N; k++) begin : g_cell
    rhc_cell #(.SHIFT(N - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (v[k]),
      .data_in  (dat[k]),
      .valid    (v[k+1]),
      .data     (dat[k+1])
    );
  end

  assign hsv_valid      = v[N];
  assign hsv.hue        = dat[N].hq;
  assign hsv.saturation = dat[N].sq;
  assign hsv.brightness = dat[N].val;

  // A valid result for a black pixel.
  assign black_out = hsv_valid && (hsv.brightness == 8'd0);

  `RHC_ASSERT_NOW(a_hue_range, hsv_valid, hsv.hue < rhc_pkg::FullTurn, "hue out of range")
  `RHC_ASSERT_NOW(a_black_sat, black_out, hsv.saturation == 8'd0, "black pixel with saturation")
  `RHC_ASSERT_NOW(a_stall_cause, pixel_stall, hsv_valid && hsv_stall, "stall without held result")
  `RHC_ASSERT_NEXT(a_held_result, hsv_valid && hsv_stall, hsv_valid, "held result dropped")

endmodule

`default_nettype wire

// File: sim/tb_rgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter_top
// Self-checking testbench for the streaming RGB to HSV converter.
// ----------------------------------------------------------------------------
// Pixels are sent from a queue by a clocked driver, with random gaps, and
// results are taken by a clocked monitor that stalls at random. Each accepted
// pixel is converted by an integer model in the testbench and the result is
// queued, and every result from the block is compared field by field with the
// oldest queued one.
`timescale 1ns / 1ps
`default_nettype none

module tb_rgb_to_hsv_converter_top;

  localparam int NumRandom  = 500;
  localparam int Latency    = 16;
  localparam int CycleLimit = 200000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            pixel_valid = 1'b0;
  logic            pixel_stall;
  rhc_pkg::pixel_t pixel = '0;
  logic            hsv_valid;
  logic            hsv_stall = 1'b0;
  rhc_pkg::hsv_t   hsv;

  rhc_pkg::pixel_t pending_pixels[$];
  rhc_pkg::hsv_t   expected_hsv[$];
  int     send_gap = 0;
  int     stall_left = 0;
  int     cycle_count = 0;
  int     mismatches = 0;
  int     results_checked = 0;
  int     pixels_sent = 0;
  bit     stimulus_done = 1'b0;

  rgb_to_hsv_converter_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hsv        (hsv)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer HSV conversion with round-to-nearest hue and saturation.
  function automatic rhc_pkg::hsv_t convert_pixel(rhc_pkg::pixel_t p);
    int unsigned r, g, b, mx, mn, d, sat, hue, num;
    rhc_pkg::hsv_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sat = 0;
    hue = 0;
    if (mx != 0) sat = (510 * d + mx) / (2 * mx);
    if (d != 0) begin
      // Red is tested first, then green, so ties go to the earlier channel.
      if (mx == r) begin
        num = (g >= b) ? 3840 * (g - b) : 23040 * d - 3840 * (b - g);
      end else if (mx == g) begin
        num = (b >= r) ? 7680 * d + 3840 * (b - r) : 7680 * d - 3840 * (r - b);
      end else begin
        num = (r >= g) ? 15360 * d + 3840 * (r - g) : 15360 * d - 3840 * (g - r);
      end
      hue = (2 * num + d) / (2 * d);
      if (hue >= 23040) hue -= 23040;
    end
    res.hue = hue[14:0];
    res.saturation = sat[7:0];
    res.brightness = mx[7:0];
    return res;
  endfunction

  function automatic rhc_pkg::pixel_t make_pixel(int r, int g, int b);
    rhc_pkg::pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    return p;
  endfunction

  // Appends one pixel to the end of the pending queue.
  function automatic void queue_pixel(int r, int g, int b);
    pending_pixels = {pending_pixels, make_pixel(r, g, b)};
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stimulus: directed corners, then mostly random pixels with some
  // deliberate ties and grays.
  initial begin
    int kind, v, a;
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(1, 1, 1);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 0, 1);
    queue_pixel(255, 1, 0);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(200, 200, 10);
    queue_pixel(10, 200, 200);
    queue_pixel(200, 10, 200);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 1, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(254, 255, 253);
    queue_pixel(3, 1, 2);
    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 9);
      v = $urandom_range(0, 255);
      a = $urandom_range(0, 255);
      if (kind == 0) begin
        queue_pixel(v, v, v);
      end else if (kind == 1) begin
        queue_pixel(v, v, a);
      end else if (kind == 2) begin
        queue_pixel(a, v, v);
      end else if (kind == 3) begin
        queue_pixel(v, a, v);
      end else begin
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
      end
    end
    stimulus_done = 1'b1;
  end

  // Reset and cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 11) rst <= 1'b0;
  end

  // Driver: presents the next pixel after a random gap and holds it until
  // the transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        expected_hsv = {expected_hsv, convert_pixel(pixel)};
        pixels_sent <= pixels_sent + 1;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (send_gap > 0) begin
          pixel_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_pixels.size() > 0) begin
          pixel_valid <= 1'b1;
          pixel <= pending_pixels.pop_front();
          send_gap <= pick_gap();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the output at random.
  always @(posedge clk) begin
    rhc_pkg::hsv_t exp_hsv;
    if (!rst) begin
      if (hsv_valid && !hsv_stall) begin
        if (expected_hsv.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", hsv);
        end else begin
          exp_hsv = expected_hsv.pop_front();
          results_checked++;
          if (hsv.hue !== exp_hsv.hue || hsv.saturation !== exp_hsv.saturation ||
              hsv.brightness !== exp_hsv.brightness) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                       exp_hsv.hue, exp_hsv.saturation, exp_hsv.brightness,
                       hsv.hue, hsv.saturation, hsv.brightness);
          end
        end
      end
      if (stall_left > 0) begin
        hsv_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ((cycle_count / 600) % 3 == 2) begin
        // Stretch of free flow.
        hsv_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        hsv_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        hsv_stall <= 1'b0;
      end
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    while (pending_pixels.size() > 0 || pixel_valid || expected_hsv.size() > 0) begin
      @(posedge clk);
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
      end
    end
    repeat (Latency + 40) @(posedge clk);
    $display("Converted %0d pixels (corners, grays, channel ties, random), %0d results checked.",
             pixels_sent, results_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
